/* hw/rtl/prq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int unsigned MAX_PROCS_DEF = 64;
  localparam int unsigned PRIO_BITS_DEF = 16;

  localparam int unsigned SLICE_W     = 16;
  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd100;

  localparam int unsigned ID_W     = 6;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned QCOUNT_W = 7;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_DUP    = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

endpackage : prq_pkg
`default_nettype wire

/* hw/rtl/prq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module prq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : prq_ram
`default_nettype wire

/* hw/rtl/prq_max_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_max_scan
// Walks every slot through the priority memory read port, one slot per
// cycle, and keeps the queued slot with the largest priority.
// ----------------------------------------------------------------------------
module prq_max_scan #(
  parameter int unsigned MAX_PROCS = 64,
  parameter int unsigned PRIO_BITS = 16,
  localparam int unsigned IDX_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [MAX_PROCS-1:0] queued,
  output logic                      rd_en,
  output logic      [IDX_W-1:0]     rd_addr,
  input  wire logic [PRIO_BITS-1:0] rd_data,
  output logic                      done,
  output logic                      found,
  output logic      [IDX_W-1:0]     best_id,
  output logic      [PRIO_BITS-1:0] best_prio
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

  logic                 run_r;
  logic [IDX_W-1:0]     cnt_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 done_r;
  logic                 found_r;
  logic [IDX_W-1:0]     best_id_r;
  logic [PRIO_BITS-1:0] best_prio_r;
  logic                 take;

  assign rd_en   = run_r;
  assign rd_addr = cnt_r;

  // The first queued slot always wins; later ones only on a strictly larger
  // priority, so ties stay with the lowest id.
  assign take = cmp_vld_r && queued[cmp_idx_r] && (!found_r || (rd_data > best_prio_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      cmp_idx_r   <= '0;
      done_r      <= 1'b0;
      found_r     <= 1'b0;
      best_id_r   <= '0;
      best_prio_r <= '0;
    end else begin
      cmp_vld_r <= run_r;
      cmp_idx_r <= cnt_r;
      done_r    <= cmp_vld_r && (cmp_idx_r == LAST_IDX);
      if (start) begin
        run_r       <= 1'b1;
        cnt_r       <= '0;
        found_r     <= 1'b0;
        best_id_r   <= '0;
        best_prio_r <= '0;
      end else begin
        if (run_r) begin
          if (cnt_r == LAST_IDX) begin
            run_r <= 1'b0;
          end else begin
            cnt_r <= cnt_r + IDX_W'(1);
          end
        end
        if (take) begin
          found_r     <= 1'b1;
          best_id_r   <= cmp_idx_r;
          best_prio_r <= rd_data;
        end
      end
    end
  end

  assign done      = done_r;
  assign found     = found_r;
  assign best_id   = best_id_r;
  assign best_prio = best_prio_r;

endmodule : prq_max_scan
`default_nettype wire

/* hw/rtl/priority_ready_queue_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ready_queue_unit
// Ready queue of a static-priority scheduler: enqueue, dequeue, tick and
// no-op items, each answered with the highest-priority queued process.
// ----------------------------------------------------------------------------
// Each accepted item passes through the execute, scan and output states; the
// maximum scan reads one slot per cycle from the priority memory. One item
// is in work at a time, so a new item is taken only after the result of the
// last one has been loaded into the output registers.
// Reset clears the queued flags, the count and the slice valid bits at once
// and loads slice_length with 100; there is no clearing pass.
module priority_ready_queue_unit
  import prq_pkg::*;
#(
  parameter int unsigned MAX_PROCS = prq_pkg::MAX_PROCS_DEF,
  parameter int unsigned PRIO_BITS = prq_pkg::PRIO_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [prq_pkg::SLICE_W-1:0]   cfg_slice_length,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [prq_pkg::ID_W-1:0]      in_process_id,
  input  wire logic [prq_pkg::PRIO_W-1:0]    in_priority_req,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic                               out_need_resched,
  output logic                               out_top_valid,
  output logic [prq_pkg::ID_W-1:0]           out_top_id,
  output logic [prq_pkg::PRIO_W-1:0]         out_top_priority,
  output logic [prq_pkg::QCOUNT_W-1:0]       out_queued_count
);

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_OUT
  } state_t;

  state_t                state_r;
  kind_t                 kind_r;
  logic [ID_W-1:0]       id_r;
  logic [PRIO_BITS-1:0]  prio_r;
  logic [SLICE_W-1:0]    slice_len_r;
  logic [MAX_PROCS-1:0]  queued_r;
  logic [MAX_PROCS-1:0]  slice_vld_r;
  logic [CNT_W-1:0]      count_r;
  status_t               stat_r;
  logic                  resched_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic                  out_resched_r;
  logic                  out_top_valid_r;
  logic [ID_W-1:0]       out_top_id_r;
  logic [PRIO_W-1:0]     out_top_prio_r;
  logic [QCOUNT_W-1:0]   out_count_r;

  logic                  in_fire;
  logic                  out_load;
  logic [IDX_W-1:0]      id_idx;
  logic                  in_range;
  logic [SLICE_W-1:0]    slice_rdata;
  logic [SLICE_W-1:0]    slice_cur;
  logic [SLICE_W-1:0]    slice_new;

  status_t               stat_nxt;
  logic                  resched_nxt;
  logic                  q_set;
  logic                  q_clr;
  logic                  prio_we;
  logic                  slice_we;
  logic [SLICE_W-1:0]    slice_wdata;

  logic                  scan_start;
  logic                  scan_rd_en;
  logic [IDX_W-1:0]      scan_rd_addr;
  logic [PRIO_BITS-1:0]  prio_rdata;
  logic                  scan_done;
  logic                  scan_found;
  logic [IDX_W-1:0]      scan_best_id;
  logic [PRIO_BITS-1:0]  scan_best_prio;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  assign id_idx    = IDX_W'(id_r);
  assign in_range  = (32'(id_r) < MAX_PROCS);
  assign slice_cur = slice_vld_r[id_idx] ? slice_rdata : '0;
  assign slice_new = (slice_cur != '0) ? (slice_cur - SLICE_W'(1)) : slice_cur;
  assign scan_start = (state_r == ST_EXEC);

  // Decode of the captured item; the slice of the named slot was read at
  // the accepting edge and is valid during the execute cycle.
  always_comb begin
    stat_nxt    = STAT_OK;
    resched_nxt = 1'b0;
    q_set       = 1'b0;
    q_clr       = 1'b0;
    prio_we     = 1'b0;
    slice_we    = 1'b0;
    slice_wdata = slice_len_r;
    if ((kind_r != KIND_NOP) && !in_range) begin
      stat_nxt = STAT_ABSENT;
    end else begin
      unique case (kind_r)
        KIND_ENQ: begin
          if (32'(count_r) >= MAX_PROCS) begin
            stat_nxt = STAT_FULL;
          end else if (queued_r[id_idx]) begin
            stat_nxt = STAT_DUP;
          end else begin
            q_set    = 1'b1;
            prio_we  = 1'b1;
            slice_we = 1'b1;
          end
        end
        KIND_DEQ: begin
          if (!queued_r[id_idx]) begin
            stat_nxt = STAT_ABSENT;
          end else begin
            q_clr = 1'b1;
          end
        end
        KIND_TICK: begin
          slice_we    = 1'b1;
          slice_wdata = slice_new;
          resched_nxt = (slice_new == '0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      slice_len_r     <= SLICE_RESET;
      queued_r        <= '0;
      slice_vld_r     <= '0;
      count_r         <= '0;
      out_valid_r     <= 1'b0;
      kind_r          <= KIND_NOP;
      id_r            <= '0;
      prio_r          <= '0;
      stat_r          <= STAT_OK;
      resched_r       <= 1'b0;
      out_status_r    <= STAT_OK;
      out_resched_r   <= 1'b0;
      out_top_valid_r <= 1'b0;
      out_top_id_r    <= '0;
      out_top_prio_r  <= '0;
      out_count_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slice_len_r <= cfg_slice_length;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            kind_r  <= kind_t'(in_kind);
            id_r    <= in_process_id;
            prio_r  <= PRIO_BITS'(in_priority_req);
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          stat_r    <= stat_nxt;
          resched_r <= resched_nxt;
          if (q_set) begin
            queued_r[id_idx] <= 1'b1;
            count_r          <= count_r + CNT_W'(1);
          end
          if (q_clr) begin
            queued_r[id_idx] <= 1'b0;
            count_r          <= count_r - CNT_W'(1);
          end
          if (slice_we) begin
            slice_vld_r[id_idx] <= 1'b1;
          end
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_status_r    <= stat_r;
            out_resched_r   <= resched_r;
            out_top_valid_r <= scan_found;
            out_top_id_r    <= ID_W'(scan_best_id);
            out_top_prio_r  <= PRIO_W'(scan_best_prio);
            out_count_r     <= QCOUNT_W'(count_r);
            state_r         <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  prq_ram #(
    .WIDTH (SLICE_W),
    .DEPTH (MAX_PROCS)
  ) u_slice_ram (
    .clk   (clk),
    .we    (slice_we && (state_r == ST_EXEC)),
    .waddr (id_idx),
    .wdata (slice_wdata),
    .re    (in_fire),
    .raddr (IDX_W'(in_process_id)),
    .rdata (slice_rdata)
  );

  prq_ram #(
    .WIDTH (PRIO_BITS),
    .DEPTH (MAX_PROCS)
  ) u_prio_ram (
    .clk   (clk),
    .we    (prio_we && (state_r == ST_EXEC)),
    .waddr (id_idx),
    .wdata (prio_r),
    .re    (scan_rd_en),
    .raddr (scan_rd_addr),
    .rdata (prio_rdata)
  );

  prq_max_scan #(
    .MAX_PROCS (MAX_PROCS),
    .PRIO_BITS (PRIO_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .queued    (queued_r),
    .rd_en     (scan_rd_en),
    .rd_addr   (scan_rd_addr),
    .rd_data   (prio_rdata),
    .done      (scan_done),
    .found     (scan_found),
    .best_id   (scan_best_id),
    .best_prio (scan_best_prio)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_need_resched = out_resched_r;
  assign out_top_valid    = out_top_valid_r;
  assign out_top_id       = out_top_id_r;
  assign out_top_priority = out_top_prio_r;
  assign out_queued_count = out_count_r;

  // The count always agrees with the number of queued flags.
  a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == 32'(count_r))
    else $error("queue count differs from the number of queued flags");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_PROCS)
    else $error("queue count above the number of slots");

  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> (state_r == ST_SCAN))
    else $error("scan finished outside the scan state");

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result item raised without a finished scan");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("new item accepted while one is in work");

endmodule : priority_ready_queue_unit
`default_nettype wire
